@@ hw/rtl/nrlt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrlt_pkg: shared types and constants of the non-wear run-length tracker
// Register codes, field widths, reset values and the per-beat control word
// that the run cells receive.
// ----------------------------------------------------------------------------
package nrlt_pkg;

	localparam int CNT_W = 16;
	localparam int TOL_W = 3;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int OUT_W = 20;

	localparam logic [OUT_W-1:0] OUT_MAX = '1;

	localparam logic [CNT_W-1:0] THR_RST = 16'd0;
	localparam logic [CNT_W-1:0] STOP_RST = 16'd100;
	localparam logic [TOL_W-1:0] TOL_RST = 3'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD,
		CFG_STOPLEVEL,
		CFG_TOLERANCE
	} cfg_idx_t;

	// decoded epoch class, shared by every cell of the row
	typedef struct packed {
		logic restart;
		logic inactive;
		logic stop;
		logic shift;
	} nrlt_op_t;

endpackage

@@ hw/rtl/nrlt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrlt_cell: one quiet-run slot of the row
// Holds one run length, takes its inward neighbour's run on a spike, and
// emits its contribution to the period sum together with the outward
// "quiet run somewhere beyond" flag.
// ----------------------------------------------------------------------------
module nrlt_cell #(
	parameter int RUN_BITS = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                acc,
	input  nrlt_pkg::nrlt_op_t  op,
	input  logic                head,
	input  logic                keep,
	input  logic [RUN_BITS-1:0] prev_run,
	input  logic                tail_in,
	output logic [RUN_BITS-1:0] run,
	output logic                tail_out,
	output logic [RUN_BITS:0]   leaf
);
	import nrlt_pkg::*;

	logic [RUN_BITS-1:0] run_q;
	logic [RUN_BITS-1:0] base;
	logic [RUN_BITS-1:0] prev_base;
	logic [RUN_BITS-1:0] run_nxt;

	always_comb begin
		base = op.restart ? '0 : run_q;
		prev_base = op.restart ? '0 : prev_run;
		if (head && op.inactive) begin
			// saturate at the top of the run counter
			run_nxt = (base == '1) ? base : base + RUN_BITS'(1);
		end else if (op.stop) begin
			run_nxt = '0;
		end else if (op.shift) begin
			run_nxt = keep ? prev_base : '0;
		end else begin
			run_nxt = base;
		end
	end

	// a tolerated spike counts only when some quiet run lies at or beyond it
	assign tail_out = keep && ((run_nxt != '0) || tail_in);

	always_comb begin
		if (!op.inactive || !keep) begin
			leaf = '0;
		end else if (head) begin
			leaf = {1'b0, run_nxt};
		end else begin
			leaf = {1'b0, run_nxt} + (RUN_BITS + 1)'(tail_out);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (acc) begin
			run_q <= run_nxt;
		end
	end

	assign run = run_q;

`ifndef ASSERT_OFF
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc && op.restart && !head |=> run_q == '0)
		else $error("non-head cell kept a run across a restart");
`endif

endmodule

@@ hw/rtl/nrlt_sum_tree.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrlt_sum_tree: registered adder tree for the period length
// Captures the row contributions, adds them pairwise one level per stage,
// saturates into the output register. Each stage stalls only when full.
// ----------------------------------------------------------------------------
module nrlt_sum_tree #(
	parameter int N      = 5,
	parameter int LEAF_W = 21
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [LEAF_W-1:0]          leaf [N],
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [nrlt_pkg::OUT_W-1:0] period_length
);
	import nrlt_pkg::*;

	localparam int L  = (N > 1) ? $clog2(N) : 1;
	localparam int P  = 1 << L;
	localparam int SW = LEAF_W + L;
	localparam int CW = (SW > OUT_W) ? SW : OUT_W;

	logic [SW-1:0]    node_s [L+1][P];
	logic [L+1:0]     vld_q;
	logic [L+1:0]     rdy;
	logic [OUT_W-1:0] period_q;

	always_comb begin
		rdy[L+1] = !vld_q[L+1] || !out_stall;
		for (int k = L; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign in_ready = rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k <= L + 1; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	for (genvar i = 0; i < P; i++) begin : g_leaf
		if (i < N) begin : g_used
			always_ff @(posedge clk) begin
				if (rdy[0] && in_valid) begin
					node_s[0][i] <= SW'(leaf[i]);
				end
			end
		end else begin : g_pad
			always_ff @(posedge clk) begin
				node_s[0][i] <= '0;
			end
		end
	end

	for (genvar l = 1; l <= L; l++) begin : g_lvl
		for (genvar i = 0; i < (P >> l); i++) begin : g_node
			always_ff @(posedge clk) begin
				if (rdy[l]) begin
					node_s[l][i] <= node_s[l-1][2*i] + node_s[l-1][2*i+1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[L+1]) begin
			if (CW'(node_s[L][0]) > CW'(OUT_MAX)) begin
				period_q <= OUT_MAX;
			end else begin
				period_q <= OUT_W'(node_s[L][0]);
			end
		end
	end

	assign out_valid = vld_q[L+1];
	assign period_length = period_q;

`ifndef ASSERT_OFF
	a_root_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall && vld_q[L] |=> vld_q[L] && $stable(node_s[L][0]))
		else $error("root sum lost while the output beat was stalled");

	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> vld_q[0] && out_valid && out_stall)
		else $error("tree refused a beat with room to spare");
`endif

endmodule

@@ hw/rtl/nonwear_run_length_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonwear_run_length_tracker: longest non-wear period per epoch
// Epoch counts arrive latest first; a row of run cells tracks the current
// quiet run and the runs behind up to MAX_TOLERANCE tolerated spikes, and a
// registered adder tree forms the period length for every epoch.
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_stall   count[15:0], restart
//  out      source     out_valid / out_stall period_length[19:0]
//  cfg      sink       cfg_we                cfg_index[1:0], cfg_data[15:0]
//
// One epoch is taken every cycle while in_stall is low; the run row updates
// in the cycle of the beat, so the next epoch can follow straight away.
// The period length passes through the leaf register, the adder tree
// levels and the saturation register.
// Reset clears the row and loads the register defaults; no sweep is needed.
// out_stall holds the tree stage by stage; in_stall rises only once every
// stage holds a beat.
// ----------------------------------------------------------------------------
module nonwear_run_length_tracker #(
	parameter int MAX_TOLERANCE = 4,
	parameter int RUN_BITS      = 20
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [nrlt_pkg::CNT_W-1:0]     count,
	input  logic                           restart,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [nrlt_pkg::OUT_W-1:0]     period_length,
	input  logic                           cfg_we,
	input  logic [nrlt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nrlt_pkg::CFG_W-1:0]     cfg_data
);
	import nrlt_pkg::*;

	localparam int ROW_LEN = MAX_TOLERANCE + 1;

	logic [CNT_W-1:0]    thr_q;
	logic [CNT_W-1:0]    stop_q;
	logic [TOL_W-1:0]    tol_q;
	logic                tree_ready;
	logic                acc;
	logic                inactive;
	nrlt_op_t            op;
	logic [RUN_BITS-1:0] run_w  [ROW_LEN];
	logic                tail_w [ROW_LEN+1];
	logic [RUN_BITS:0]   leaf_w [ROW_LEN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RST;
			stop_q <= STOP_RST;
			tol_q <= TOL_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_THRESHOLD: thr_q <= cfg_data;
				CFG_STOPLEVEL: stop_q <= cfg_data;
				CFG_TOLERANCE: tol_q <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_stall = !tree_ready;
	assign acc = in_valid && tree_ready;

	// the activity test wins over the stop level
	assign inactive = count <= thr_q;
	always_comb begin
		op.restart = restart;
		op.inactive = inactive;
		op.stop = !inactive && (count > stop_q);
		op.shift = !inactive && (count <= stop_q);
	end

	assign tail_w[ROW_LEN] = 1'b0;

	for (genvar j = 0; j < ROW_LEN; j++) begin : g_cell
		logic [RUN_BITS-1:0] prev;
		if (j == 0) begin : g_head
			assign prev = '0;
		end else begin : g_body
			assign prev = run_w[j-1];
		end

		nrlt_cell #(
			.RUN_BITS(RUN_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.acc     (acc),
			.op      (op),
			.head    (1'(j == 0)),
			.keep    (int'(tol_q) >= j),
			.prev_run(prev),
			.tail_in (tail_w[j+1]),
			.run     (run_w[j]),
			.tail_out(tail_w[j]),
			.leaf    (leaf_w[j])
		);
	end

	nrlt_sum_tree #(
		.N     (ROW_LEN),
		.LEAF_W(RUN_BITS + 1)
	) u_tree (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (tree_ready),
		.leaf         (leaf_w),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.period_length(period_length)
	);

`ifndef ASSERT_OFF
	a_quiet_grows: assert property (@(posedge clk) disable iff (!arst_n)
		acc && inactive |=> run_w[0] != '0)
		else $error("current run empty after a quiet epoch");

	a_spike_resets: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !inactive |=> run_w[0] == '0)
		else $error("current run survived a spike");

	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a waiting output beat");
`endif

endmodule
